// ----- rtl/ssis_pkg.sv -----
// ssis_pkg: widths, register codes, pipeline structs and the saturation helper
// for the segment slope/intercept stream unit.
// No dependencies; every other file in rtl/ imports it.
package ssis_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned MIN_LENGTH = 2;

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LENGTH);

  localparam int unsigned SMP_W  = 24;
  localparam int unsigned D_W    = SMP_W + 1;
  localparam int unsigned SEG_W  = 12;
  localparam int unsigned COEF_W = 37;
  localparam int unsigned DIFF_W = 38;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned WLEN_W = 13;

  // Working width for products plus one add, never below the saturation range.
  localparam int unsigned WIDE_W = (SMP_W + LEN_W + 3 > COEF_W + 1) ?
                                   (SMP_W + LEN_W + 3) : (COEF_W + 1);

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM_TAG = CFG_IDX_W'(1);

  localparam logic [WLEN_W-1:0] WAVE_LENGTH_RST  = WLEN_W'(2048);
  localparam logic [TAG_W-1:0]  WAVEFORM_TAG_RST = TAG_W'(0);

  // Result buffer: one final sample pushes up to three results at once.
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned NRES_W    = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } cfg_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] y0;
    logic signed [SMP_W-1:0] fv;
    logic [IDX_W-1:0]        k;
    logic [LEN_W-1:0]        len;
    logic                    is_final;
    logic [TAG_W-1:0]        tag;
  } seg_work_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] m;
    logic signed [COEF_W-1:0] q;
    logic signed [COEF_W-1:0] mw;
    logic signed [COEF_W-1:0] qw;
    logic [IDX_W-1:0]         k;
    logic                     emit_prev;
    logic                     is_final;
    logic [TAG_W-1:0]         tag;
  } seg_coef_t;

  typedef struct packed {
    logic [SEG_W-1:0]         segment_index;
    logic signed [COEF_W-1:0] slope;
    logic signed [COEF_W-1:0] intercept;
    logic signed [DIFF_W-1:0] slope_diff;
    logic signed [DIFF_W-1:0] intercept_diff;
    logic [TAG_W-1:0]         tag;
    logic                     last;
  } result_t;

  function automatic logic signed [COEF_W-1:0] sat_coef(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(COEF_MAX);
    lo = WIDE_W'(COEF_MIN);
    if (v > hi) begin
      return COEF_MAX;
    end else if (v < lo) begin
      return COEF_MIN;
    end
    return COEF_W'(v);
  endfunction

endpackage

// ----- rtl/ssis_if.sv -----
// ssis_if: valid/ready channel interfaces for samples, results and config writes.
// Depends on ssis_pkg for field widths.
interface ssis_sample_if import ssis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ssis_result_if import ssis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SEG_W-1:0]         segment_index;
  logic signed [COEF_W-1:0] slope;
  logic signed [COEF_W-1:0] intercept;
  logic signed [DIFF_W-1:0] slope_diff;
  logic signed [DIFF_W-1:0] intercept_diff;
  logic [TAG_W-1:0]         tag;
  logic                     last;

  modport source (output valid, output segment_index, output slope, output intercept,
                  output slope_diff, output intercept_diff, output tag, output last,
                  input ready);
  modport sink   (input valid, input segment_index, input slope, input intercept,
                  input slope_diff, input intercept_diff, input tag, input last,
                  output ready);
endinterface

interface ssis_cfg_if import ssis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ssis_cfg_regs.sv -----
// ssis_cfg_regs: wave_length and waveform_tag registers, with length clamping.
// Depends on ssis_pkg and ssis_cfg_if.
module ssis_cfg_regs import ssis_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssis_cfg_if.sink        cfg_i,
  output cfg_t            cfg_o
);

  logic [WLEN_W-1:0] wave_length_q;
  logic [TAG_W-1:0]  tag_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_length_q <= WAVE_LENGTH_RST;
      tag_q         <= WAVEFORM_TAG_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WAVE_LENGTH:  wave_length_q <= WLEN_W'(cfg_i.data);
        REG_WAVEFORM_TAG: tag_q         <= TAG_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Clamp the effective length to [MIN_LENGTH, MAX_LENGTH].
  always_comb begin
    if (32'(wave_length_q) < MIN_LENGTH) begin
      cfg_o.len = LEN_W'(MIN_LENGTH);
    end else if (32'(wave_length_q) > MAX_LENGTH) begin
      cfg_o.len = LEN_W'(MAX_LENGTH);
    end else begin
      cfg_o.len = LEN_W'(wave_length_q);
    end
    cfg_o.tag = tag_q;
  end

endmodule

// ----- rtl/ssis_front.sv -----
// ssis_front: sample acceptance, sample counter and first/previous sample store;
// registers one segment work item per accepted sample but the first of each waveform.
// Depends on ssis_pkg and ssis_sample_if.
module ssis_front import ssis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssis_sample_if.sink sample_i,
  input  cfg_t       cfg_i,
  input  logic       work_ready_i,
  output seg_work_t  work_o,
  output logic       work_valid_o
);

  logic [IDX_W-1:0]        count_q;
  logic signed [SMP_W-1:0] first_q;
  logic signed [SMP_W-1:0] prev_q;
  seg_work_t               work_q;
  logic                    work_valid_q;

  logic take;
  logic is_start;
  logic is_final;

  assign sample_i.ready = !work_valid_q || work_ready_i;
  assign take           = sample_i.valid && sample_i.ready;
  assign is_start       = (count_q == '0);
  assign is_final       = !is_start && ((LEN_W'(count_q) + LEN_W'(1)) >= cfg_i.len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      work_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= is_final ? '0 : count_q + IDX_W'(1);
      end
      if (take && !is_start) begin
        work_valid_q <= 1'b1;
      end else if (work_ready_i) begin
        work_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prev_q <= sample_i.sample;
      if (is_start) begin
        first_q <= sample_i.sample;
      end else begin
        work_q.y        <= sample_i.sample;
        work_q.y0       <= prev_q;
        work_q.fv       <= first_q;
        work_q.k        <= count_q;
        work_q.len      <= cfg_i.len;
        work_q.is_final <= is_final;
        work_q.tag      <= cfg_i.tag;
      end
    end
  end

  assign work_o       = work_q;
  assign work_valid_o = work_valid_q;

endmodule

// ----- rtl/ssis_coeff.sv -----
// ssis_coeff: slope and intercept of the closing segment and of the wrap segment,
// saturated and registered.
// Depends on ssis_pkg.
module ssis_coeff import ssis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seg_work_t work_i,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  logic      coef_fire_i,
  output seg_coef_t coef_o,
  output logic      coef_valid_o
);

  seg_coef_t coef_q;
  logic      coef_valid_q;

  logic signed [D_W-1:0]       d;
  logic signed [D_W-1:0]       dw;
  logic signed [LEN_W:0]       len_s;
  logic signed [IDX_W:0]       k_s;
  logic signed [IDX_W:0]       km1_s;
  logic signed [D_W+LEN_W:0]   prod_m;
  logic signed [D_W+LEN_W:0]   prod_mw;
  logic signed [D_W+IDX_W:0]   prod_q;
  logic signed [D_W+IDX_W:0]   prod_qw;
  seg_coef_t                   coef_d;

  assign work_ready_o = !coef_valid_q || coef_fire_i;

  always_comb begin
    d       = D_W'(work_i.y) - D_W'(work_i.y0);
    dw      = D_W'(work_i.fv) - D_W'(work_i.y);
    len_s   = $signed({1'b0, work_i.len});
    k_s     = $signed({1'b0, work_i.k});
    // The closing segment starts at the previous sample, index k-1 (k is never zero here).
    km1_s   = $signed({1'b0, work_i.k - IDX_W'(1)});
    prod_m  = d * len_s;
    prod_mw = dw * len_s;
    prod_q  = d * km1_s;
    prod_qw = dw * k_s;

    coef_d.m         = sat_coef(WIDE_W'(prod_m));
    coef_d.q         = sat_coef(WIDE_W'(work_i.y0) - WIDE_W'(prod_q));
    coef_d.mw        = sat_coef(WIDE_W'(prod_mw));
    coef_d.qw        = sat_coef(WIDE_W'(work_i.y) - WIDE_W'(prod_qw));
    coef_d.k         = work_i.k;
    coef_d.emit_prev = (work_i.k != IDX_W'(1));
    coef_d.is_final  = work_i.is_final;
    coef_d.tag       = work_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_valid_q <= 1'b0;
    end else if (work_ready_o) begin
      coef_valid_q <= work_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_ready_o && work_valid_i) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o       = coef_q;
  assign coef_valid_o = coef_valid_q;

endmodule

// ----- rtl/ssis_emit.sv -----
// ssis_emit: pending and first-segment coefficient store; assembles the results
// one segment step produces, with their cyclic differences.
// Depends on ssis_pkg.
module ssis_emit import ssis_pkg::*; (
  input  logic              clk_i,
  input  seg_coef_t         coef_i,
  input  logic              coef_valid_i,
  input  logic [RES_CNT_W-1:0] free_i,
  output logic              fire_o,
  output logic [NRES_W-1:0] push_n_o,
  output result_t           slot_o [MAX_RES]
);

  logic signed [COEF_W-1:0] pend_m_q;
  logic signed [COEF_W-1:0] pend_q_q;
  logic signed [COEF_W-1:0] first_m_q;
  logic signed [COEF_W-1:0] first_q_q;

  logic signed [COEF_W-1:0] fs;
  logic signed [COEF_W-1:0] fi;
  logic [NRES_W-1:0]        n;
  result_t                  r_prev;
  result_t                  r_close;
  result_t                  r_wrap;

  always_comb begin
    n = NRES_W'(coef_i.emit_prev) + (coef_i.is_final ? NRES_W'(2) : '0);

    // The second sample closes the segment that opens the waveform: its coefficients are the first.
    fs = coef_i.emit_prev ? first_m_q : coef_i.m;
    fi = coef_i.emit_prev ? first_q_q : coef_i.q;

    r_prev.segment_index  = SEG_W'(coef_i.k - IDX_W'(2));
    r_prev.slope          = pend_m_q;
    r_prev.intercept      = pend_q_q;
    r_prev.slope_diff     = DIFF_W'(coef_i.m) - DIFF_W'(pend_m_q);
    r_prev.intercept_diff = DIFF_W'(coef_i.q) - DIFF_W'(pend_q_q);
    r_prev.tag            = coef_i.tag;
    r_prev.last           = 1'b0;

    r_close.segment_index  = SEG_W'(coef_i.k - IDX_W'(1));
    r_close.slope          = coef_i.m;
    r_close.intercept      = coef_i.q;
    r_close.slope_diff     = DIFF_W'(coef_i.mw) - DIFF_W'(coef_i.m);
    r_close.intercept_diff = DIFF_W'(coef_i.qw) - DIFF_W'(coef_i.q);
    r_close.tag            = coef_i.tag;
    r_close.last           = 1'b0;

    r_wrap.segment_index  = SEG_W'(coef_i.k);
    r_wrap.slope          = coef_i.mw;
    r_wrap.intercept      = coef_i.qw;
    r_wrap.slope_diff     = DIFF_W'(fs) - DIFF_W'(coef_i.mw);
    r_wrap.intercept_diff = DIFF_W'(fi) - DIFF_W'(coef_i.qw);
    r_wrap.tag            = coef_i.tag;
    r_wrap.last           = 1'b1;

    // Pack in emission order.
    slot_o[0] = coef_i.emit_prev ? r_prev : r_close;
    slot_o[1] = coef_i.emit_prev ? r_close : r_wrap;
    slot_o[2] = r_wrap;
  end

  assign fire_o   = coef_valid_i && (RES_CNT_W'(n) <= free_i);
  assign push_n_o = fire_o ? n : '0;

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      pend_m_q <= coef_i.m;
      pend_q_q <= coef_i.q;
      if (!coef_i.emit_prev) begin
        first_m_q <= coef_i.m;
        first_q_q <= coef_i.q;
      end
    end
  end

endmodule

// ----- rtl/ssis_result_fifo.sv -----
// ssis_result_fifo: small result buffer, up to three pushes and one pop a cycle;
// drives the result channel.
// Depends on ssis_pkg and ssis_result_if.
module ssis_result_fifo import ssis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NRES_W-1:0]    push_n_i,
  input  result_t              slot_i [MAX_RES],
  output logic [RES_CNT_W-1:0] free_o,
  ssis_result_if.source        res_o
);

  result_t                mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_q;
  logic [RES_PTR_W-1:0]   rd_q;
  logic [RES_CNT_W-1:0]   count_q;
  logic [RES_PTR_W-1:0]   off [RES_DEPTH];
  logic                   pop;
  result_t                head;

  assign pop    = res_o.valid && res_o.ready;
  assign free_o = RES_CNT_W'(RES_DEPTH) - count_q + RES_CNT_W'(pop);

  always_comb begin
    for (int e = 0; e < RES_DEPTH; e++) begin
      off[e] = RES_PTR_W'(e) - wr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + RES_PTR_W'(push_n_i);
      rd_q    <= rd_q + RES_PTR_W'(pop);
      count_q <= count_q + RES_CNT_W'(push_n_i) - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < RES_DEPTH; e++) begin
      if (RES_CNT_W'(off[e]) < RES_CNT_W'(push_n_i)) begin
        mem_q[e] <= slot_i[off[e]];
      end
    end
  end

  assign head                 = mem_q[rd_q];
  assign res_o.valid          = (count_q != '0);
  assign res_o.segment_index  = head.segment_index;
  assign res_o.slope          = head.slope;
  assign res_o.intercept      = head.intercept;
  assign res_o.slope_diff     = head.slope_diff;
  assign res_o.intercept_diff = head.intercept_diff;
  assign res_o.tag            = head.tag;
  assign res_o.last           = head.last;

endmodule

// ----- rtl/segment_slope_intercept_stream_unit.sv -----
// Path: a sample's first result passes the work item register, the coefficient
// register and the result buffer before it is valid on out_o; the first sample of
// a waveform yields no result.
// Throughput: one sample per cycle. The final sample pushes up to three results into
// the four-entry result buffer; the input stalls only while that buffer lacks room.
// Reset: sample counter to zero, wave_length to 2048, waveform_tag to 0, all
// pipeline stages and the result buffer empty.
module segment_slope_intercept_stream_unit import ssis_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssis_sample_if.sink   in_i,
  ssis_cfg_if.sink      cfg_i,
  ssis_result_if.source out_o
);

  cfg_t              cfg;
  seg_work_t         work;
  logic              work_valid;
  logic              work_ready;
  seg_coef_t         coef;
  logic              coef_valid;
  logic              coef_fire;
  logic [NRES_W-1:0] push_n;
  logic [RES_CNT_W-1:0] free;
  result_t           slots [MAX_RES];

  // Config registers; length is clamped here once for the whole pipe.
  ssis_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Stage 1: count samples, hold first/previous sample, register the work item.
  ssis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (in_i),
    .cfg_i        (cfg),
    .work_ready_i (work_ready),
    .work_o       (work),
    .work_valid_o (work_valid)
  );

  // Stage 2: multiply out slope and intercept, saturate, register.
  ssis_coeff u_coeff (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work),
    .work_valid_i (work_valid),
    .work_ready_o (work_ready),
    .coef_fire_i  (coef_fire),
    .coef_o       (coef),
    .coef_valid_o (coef_valid)
  );

  // Form the cyclic differences; advance only when the buffer can take all results.
  ssis_emit u_emit (
    .clk_i        (clk_i),
    .coef_i       (coef),
    .coef_valid_i (coef_valid),
    .free_i       (free),
    .fire_o       (coef_fire),
    .push_n_o     (push_n),
    .slot_o       (slots)
  );

  // Result buffer parts the pipe from the output handshake.
  ssis_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .slot_i   (slots),
    .free_o   (free),
    .res_o    (out_o)
  );

endmodule

// ----- rtl/ssis_checker.sv -----
// ssis_checker: port-level checks on the result stream of the top level,
// attached by bind. Depends on ssis_pkg.
module ssis_checker import ssis_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [SEG_W-1:0]         segment_index_i,
  input logic signed [COEF_W-1:0] slope_i,
  input logic signed [COEF_W-1:0] intercept_i,
  input logic signed [DIFF_W-1:0] slope_diff_i,
  input logic signed [DIFF_W-1:0] intercept_diff_i,
  input logic                     last_i
);

  logic                     beat;
  logic [SEG_W-1:0]         exp_idx_q;
  logic                     open_q;
  logic                     have_first_q;
  logic signed [COEF_W-1:0] prev_slope_q;
  logic signed [COEF_W-1:0] prev_icpt_q;
  logic signed [DIFF_W-1:0] prev_sdiff_q;
  logic signed [DIFF_W-1:0] prev_idiff_q;
  logic signed [COEF_W-1:0] first_slope_q;
  logic signed [COEF_W-1:0] first_icpt_q;

  assign beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q    <= '0;
      open_q       <= 1'b0;
      have_first_q <= 1'b0;
    end else if (beat) begin
      exp_idx_q <= last_i ? '0 : segment_index_i + SEG_W'(1);
      open_q    <= !last_i;
      if (segment_index_i == '0) begin
        have_first_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      prev_slope_q <= slope_i;
      prev_icpt_q  <= intercept_i;
      prev_sdiff_q <= slope_diff_i;
      prev_idiff_q <= intercept_diff_i;
      if (segment_index_i == '0) begin
        first_slope_q <= slope_i;
        first_icpt_q  <= intercept_i;
      end
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |-> segment_index_i == exp_idx_q)
    else $error("segment index out of sequence");

  a_slope_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && open_q |-> DIFF_W'(slope_i) == DIFF_W'(prev_slope_q) + prev_sdiff_q)
    else $error("slope does not match previous slope plus its difference");

  a_icpt_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && open_q |-> DIFF_W'(intercept_i) == DIFF_W'(prev_icpt_q) + prev_idiff_q)
    else $error("intercept does not match previous intercept plus its difference");

  a_wrap_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && last_i && have_first_q |->
      (DIFF_W'(slope_i) + slope_diff_i == DIFF_W'(first_slope_q)) &&
      (DIFF_W'(intercept_i) + intercept_diff_i == DIFF_W'(first_icpt_q)))
    else $error("wrap segment differences do not close on the first segment");

endmodule

bind segment_slope_intercept_stream_unit ssis_checker u_ssis_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .segment_index_i  (out_o.segment_index),
  .slope_i          (out_o.slope),
  .intercept_i      (out_o.intercept),
  .slope_diff_i     (out_o.slope_diff),
  .intercept_diff_i (out_o.intercept_diff),
  .last_i           (out_o.last)
);
